// File: rtl/core/bmw_pkg.sv
// Shared constants, register codes and cell control types for the morphology window.
package bmw_pkg;

  // Sizing
  localparam int MAX_IMAGE_WIDTH  = 1024;
  localparam int MAX_ELEMENT_SIZE = 7;
  localparam int MAX_IMAGE_HEIGHT = 1024;

  // Window side: the element register layout caps it at seven
  localparam int MASK_STRIDE = 7;
  localparam int WIN         = (MAX_ELEMENT_SIZE < MASK_STRIDE) ? MAX_ELEMENT_SIZE : MASK_STRIDE;
  localparam int HALF        = WIN / 2;
  localparam int LINE_W      = WIN - 1;

  localparam int COL_W = $clog2(MAX_IMAGE_WIDTH);
  localparam int WID_W = COL_W + 1;
  localparam int ROW_W = $clog2(MAX_IMAGE_HEIGHT);
  localparam int HGT_W = ROW_W + 1;
  localparam int DLY_W = $clog2(HALF * MAX_IMAGE_WIDTH + HALF + 1);

  // Field widths
  localparam int RGB_W      = 8 * 3;
  localparam int DIM_W      = 11;
  localparam int ELEM_W     = 3;
  localparam int MASK_W     = 49;
  localparam int XY_W       = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 49;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_ELEMENT_WIDTH,
    REG_ELEMENT_HEIGHT,
    REG_ELEMENT_MASK,
    REG_FOREGROUND_RGB,
    REG_BACKGROUND_RGB,
    REG_OP_MODE
  } cfg_reg_t;

  // Per-cell evaluation controls: element column, rows inside the image, column inside
  typedef struct packed {
    logic [WIN-1:0] mask;
    logic [WIN-1:0] row_ok;
    logic           col_ok;
  } cell_sel_t;

  typedef struct packed {
    logic bad;   // masked, inside, background
    logic hit;   // masked, inside, foreground
  } cell_flags_t;

endpackage

// File: rtl/core/bmw_line_store.sv
// Line store: per-column history of the last rows' foreground bits, with write bypass.
module bmw_line_store import bmw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [COL_W-1:0]  rd_addr,
  input  logic              wr_en,
  input  logic [COL_W-1:0]  wr_addr,
  input  logic [LINE_W-1:0] wr_data,
  output logic [LINE_W-1:0] rd_data
);

  logic [LINE_W-1:0] mem [MAX_IMAGE_WIDTH];
  logic [LINE_W-1:0] rd_q;
  logic [LINE_W-1:0] byp_q;
  logic              byp_sel;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q  <= mem[rd_addr];
      byp_q <= wr_data;
    end
  end

  // same column written and read on one edge (one-pixel-wide image)
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_sel <= 1'b0;
    end else if (rd_en) begin
      byp_sel <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = byp_sel ? byp_q : rd_q;

endmodule

// File: rtl/core/bmw_cell.sv
// Window cell: holds one column of foreground bits and scores it against the element.
module bmw_cell import bmw_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           shift,
  input  logic [WIN-1:0] col_in,
  input  cell_sel_t      sel,
  output logic [WIN-1:0] col_out,
  output cell_flags_t    flags
);

  logic [WIN-1:0] col_q;
  logic [WIN-1:0] live;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_q <= '0;
    end else if (shift) begin
      col_q <= col_in;
    end
  end

  assign col_out   = col_q;
  assign live      = sel.mask & sel.row_ok & {WIN{sel.col_ok}};
  assign flags.bad = |(live & ~col_q);
  assign flags.hit = |(live & col_q);

endmodule

// File: rtl/core/binary_morphology_window.sv
// Top level of the binary erosion / dilation window over a raster RGB pixel stream.
//
// Pixels arrive one beat at a time in raster order; a pixel is foreground when its RGB equals
// foreground_rgb. Each result beat carries the eroded (op_mode 0) or dilated (op_mode 1) value
// of one image position as foreground_rgb or background_rgb, its column and row, and a flag on
// the last position of the frame. Element positions off the image are ignored. Results lag the
// input by (element_height/2) rows plus (element_width/2) pixels, so the producer follows each
// frame with that many padding beats to flush it; after the last_pixel beat the next input
// starts a new frame. Throughput is one pixel per clock unless the sink stalls: the line store
// gives one column read and one column write per clock and the window is a row of seven column
// cells that shift once per pixel beat. A pixel beat releases its result through the line store
// read, window shift and result register. The block takes no pixel in the clock after reset and
// after each configuration beat, while the derived sizes and element map are reloaded; a
// configuration beat also restarts the frame. The line store needs no clearing pass: stale
// entries only ever sit at positions outside the current frame, which are masked by coordinate.
module binary_morphology_window import bmw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [RGB_W-1:0]      pixel_rgb,
  input  logic                  is_padding,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [RGB_W-1:0]      result_rgb,
  output logic [XY_W-1:0]       out_x,
  output logic [XY_W-1:0]       out_y,
  output logic                  last_pixel,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             fg;
    logic             emit;
    logic             last;
    logic [COL_W-1:0] ox;
    logic [ROW_W-1:0] oy;
  } s1_t;

  typedef struct packed {
    logic             last;
    logic [COL_W-1:0] ox;
    logic [ROW_W-1:0] oy;
    logic [WIN-1:0]   row_ok;
    logic [WIN-1:0]   col_ok;
  } s2_t;

  // ---------------------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------------------
  logic [DIM_W-1:0]  image_width;
  logic [DIM_W-1:0]  image_height;
  logic [ELEM_W-1:0] element_width;
  logic [ELEM_W-1:0] element_height;
  logic [MASK_W-1:0] element_mask;
  logic [RGB_W-1:0]  foreground_rgb;
  logic [RGB_W-1:0]  background_rgb;
  logic              op_mode;
  logic              cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= DIM_W'(640);
      image_height   <= DIM_W'(480);
      element_width  <= ELEM_W'(3);
      element_height <= ELEM_W'(3);
      element_mask   <= MASK_W'(115591);
      foreground_rgb <= '0;
      background_rgb <= '1;
      op_mode        <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:    image_width    <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT:   image_height   <= cfg_data[DIM_W-1:0];
        REG_ELEMENT_WIDTH:  element_width  <= cfg_data[ELEM_W-1:0];
        REG_ELEMENT_HEIGHT: element_height <= cfg_data[ELEM_W-1:0];
        REG_ELEMENT_MASK:   element_mask   <= cfg_data[MASK_W-1:0];
        REG_FOREGROUND_RGB: foreground_rgb <= cfg_data[RGB_W-1:0];
        REG_BACKGROUND_RGB: background_rgb <= cfg_data[RGB_W-1:0];
        REG_OP_MODE:        op_mode        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------------------
  // Derived sizes: clamped, reloaded every clock
  // ---------------------------------------------------------------------------------------
  logic [WID_W-1:0]  w_c;
  logic [HGT_W-1:0]  h_c;
  logic [ELEM_W-1:0] ew_c, eh_c, cx_c, cy_c;
  logic [WIN-1:0]    em_c [WIN];

  logic [WID_W-1:0]  w_eff;
  logic [COL_W-1:0]  w_last;
  logic [HGT_W-1:0]  h_eff;
  logic [ROW_W-1:0]  h_last;
  logic [ELEM_W-1:0] cx_q, cy_q;
  logic [DLY_W-1:0]  delay_q;
  logic [WIN-1:0]    em_q [WIN];

  always_comb begin
    if (image_width == '0) begin
      w_c = WID_W'(1);
    end else if (int'(image_width) > MAX_IMAGE_WIDTH) begin
      w_c = WID_W'(MAX_IMAGE_WIDTH);
    end else begin
      w_c = WID_W'(image_width);
    end
    if (image_height == '0) begin
      h_c = HGT_W'(1);
    end else if (int'(image_height) > MAX_IMAGE_HEIGHT) begin
      h_c = HGT_W'(MAX_IMAGE_HEIGHT);
    end else begin
      h_c = HGT_W'(image_height);
    end
    if (element_width == '0) begin
      ew_c = ELEM_W'(1);
    end else if (int'(element_width) > WIN) begin
      ew_c = ELEM_W'(WIN);
    end else begin
      ew_c = element_width;
    end
    if (element_height == '0) begin
      eh_c = ELEM_W'(1);
    end else if (int'(element_height) > WIN) begin
      eh_c = ELEM_W'(WIN);
    end else begin
      eh_c = element_height;
    end
    cx_c = ew_c >> 1;
    cy_c = eh_c >> 1;
  end

  // Element map in window terms: cell k holds the pixel k beats back, bit j the row j back.
  // Dilation reads the element straight; erosion reads it mirrored about its centre.
  always_comb begin
    int ii;
    int jj;
    ii = 0;
    jj = 0;
    for (int k = 0; k < WIN; k++) begin
      for (int j = 0; j < WIN; j++) begin
        em_c[k][j] = 1'b0;
        if (op_mode) begin
          if (k < int'(ew_c) && j < int'(eh_c)) begin
            em_c[k][j] = element_mask[j*MASK_STRIDE+k];
          end
        end else begin
          ii = 2 * int'(cx_c) - k;
          jj = 2 * int'(cy_c) - j;
          if (ii >= 0 && ii < int'(ew_c) && jj >= 0 && jj < int'(eh_c)) begin
            em_c[k][j] = element_mask[jj*MASK_STRIDE+ii];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    w_eff   <= w_c;
    w_last  <= COL_W'(w_c - WID_W'(1));
    h_eff   <= h_c;
    h_last  <= ROW_W'(h_c - HGT_W'(1));
    cx_q    <= cx_c;
    cy_q    <= cy_c;
    delay_q <= DLY_W'(cy_c) * DLY_W'(w_c) + DLY_W'(cx_c);
    em_q    <= em_c;
  end

  // ---------------------------------------------------------------------------------------
  // Flow control: every stage moves together when the result register is free
  // ---------------------------------------------------------------------------------------
  logic advance;
  logic accept;
  logic settle;

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance && !settle;
  assign accept   = in_valid && in_ready;

  // ---------------------------------------------------------------------------------------
  // Stage 0: input column, fill count and output position
  // ---------------------------------------------------------------------------------------
  logic [COL_W-1:0] in_col;
  logic [DLY_W-1:0] fill;
  logic [COL_W-1:0] ox;
  logic [ROW_W-1:0] oy;
  logic             emit;
  logic             last0;
  logic             fg_new;
  logic [WID_W-1:0] col_inc;
  logic [WID_W-1:0] ox_inc;

  assign emit    = (fill == delay_q);
  assign last0   = (ox == w_last) && (oy == h_last);
  assign fg_new  = !is_padding && (pixel_rgb == foreground_rgb);
  assign col_inc = WID_W'(in_col) + WID_W'(1);
  assign ox_inc  = WID_W'(ox) + WID_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col <= '0;
      fill   <= '0;
      ox     <= '0;
      oy     <= '0;
      settle <= 1'b1;
    end else begin
      settle <= cfg_we;
      if (cfg_we) begin
        in_col <= '0;
        fill   <= '0;
        ox     <= '0;
        oy     <= '0;
      end else if (accept) begin
        if (emit && last0) begin
          // frame done: next beat is the first pixel of a new frame
          in_col <= '0;
          fill   <= '0;
          ox     <= '0;
          oy     <= '0;
        end else begin
          in_col <= (col_inc >= w_eff) ? '0 : COL_W'(col_inc);
          if (!emit) begin
            fill <= fill + DLY_W'(1);
          end else if (ox_inc >= w_eff) begin
            ox <= '0;
            oy <= oy + ROW_W'(1);
          end else begin
            ox <= COL_W'(ox_inc);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 1: line store read returns; column vector formed; edge masks computed
  // ---------------------------------------------------------------------------------------
  logic              s1_valid;
  s1_t               s1_q;
  logic [LINE_W-1:0] line_rd;
  logic [WIN-1:0]    col_vec;
  logic [HGT_W-1:0]  posy;
  logic [WID_W-1:0]  posx;
  logic [WIN-1:0]    row_ok;
  logic [WIN-1:0]    col_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_q <= '{col: in_col, fg: fg_new, emit: emit, last: last0, ox: ox, oy: oy};
    end
  end

  bmw_line_store u_line_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (advance),
    .rd_addr (in_col),
    .wr_en   (advance && s1_valid),
    .wr_addr (s1_q.col),
    .wr_data (col_vec[LINE_W-1:0]),
    .rd_data (line_rd)
  );

  // bit 0 is the new pixel, bit j the pixel j rows above
  assign col_vec = {line_rd, s1_q.fg};

  // cell (j, k) sits at row oy+cy-j, column ox+cx-k of the image
  assign posy = HGT_W'(s1_q.oy) + HGT_W'(cy_q);
  assign posx = WID_W'(s1_q.ox) + WID_W'(cx_q);

  always_comb begin
    for (int j = 0; j < WIN; j++) begin
      row_ok[j] = (int'(posy) >= j) && (int'(posy) - j < int'(h_eff));
      col_ok[j] = (int'(posx) >= j) && (int'(posx) - j < int'(w_eff));
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 2: window cells hold the newest seven columns; score them
  // ---------------------------------------------------------------------------------------
  logic           s2_valid;
  s2_t            s2_q;
  logic [WIN-1:0] win_col [WIN];
  cell_sel_t      sel     [WIN];
  cell_flags_t    flags   [WIN];
  logic [WIN-1:0] bad_vec;
  logic [WIN-1:0] hit_vec;
  logic           fg_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid && s1_q.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_q <= '{last: s1_q.last, ox: s1_q.ox, oy: s1_q.oy, row_ok: row_ok, col_ok: col_ok};
    end
  end

  for (genvar g = 0; g < WIN; g++) begin : g_cell
    logic [WIN-1:0] feed;

    if (g == 0) begin : g_head
      assign feed = col_vec;
    end else begin : g_link
      assign feed = win_col[g-1];
    end

    assign sel[g] = {em_q[g], s2_q.row_ok, s2_q.col_ok[g]};

    bmw_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .shift   (advance && s1_valid),
      .col_in  (feed),
      .sel     (sel[g]),
      .col_out (win_col[g]),
      .flags   (flags[g])
    );

    assign bad_vec[g] = flags[g].bad;
    assign hit_vec[g] = flags[g].hit;
  end

  // erosion: nothing masked and inside is background; dilation: something masked is foreground
  assign fg_res = op_mode ? |hit_vec : ~|bad_vec;

  // ---------------------------------------------------------------------------------------
  // Stage 3: result register
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_rgb <= fg_res ? foreground_rgb : background_rgb;
      out_x      <= XY_W'(s2_q.ox);
      out_y      <= XY_W'(s2_q.oy);
      last_pixel <= s2_q.last;
    end
  end

`ifndef SYNTH
  // a configuration beat blocks pixel input in the clock after it, while the derived sizes reload
  a_settle_after_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("pixel beat taken while derived sizes reload");

  // every result lies inside the configured image
  a_result_inside: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_x <= XY_W'(w_last)) && (out_y <= XY_W'(h_last)))
    else $error("result position outside the image");

  // the frame-end flag sits on the bottom-right pixel only
  a_last_corner: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_pixel |-> (out_x == XY_W'(w_last)) && (out_y == XY_W'(h_last)))
    else $error("last pixel flag away from the frame corner");
`endif

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the binary erosion / dilation window with a built-in pixel predictor.
module tb_top import bmw_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Predictor store depth: twice the largest window delay plus one
  localparam int STORE_DEPTH   = 2 * (3 * 1024 + 3) + 1;
  localparam bit OP_ERODE      = 1'b0;
  localparam bit OP_DILATE     = 1'b1;
  // Frame shapes used by the stimulus
  localparam int FRAME_CLEAN   = 0;
  localparam int FRAME_CUT     = 1;
  localparam int FRAME_NOISE   = 2;
  // Give the pipeline a margin to clear before touching registers
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_BEATS   = 320;

  typedef struct {
    logic [RGB_W-1:0] rgb;
    logic [XY_W-1:0]  x;
    logic [XY_W-1:0]  y;
    logic             last;
  } px_result_t;

  // Predicts every output pixel from the accepted input beats and checks the result beats
  class morph_checker;
    logic [DIM_W-1:0]  img_w   = 11'd640;
    logic [DIM_W-1:0]  img_h   = 11'd480;
    logic [ELEM_W-1:0] el_w    = 3'd3;
    logic [ELEM_W-1:0] el_h    = 3'd3;
    logic [MASK_W-1:0] el_mask = 49'd115591;
    logic [RGB_W-1:0]  fg_rgb  = 24'h000000;
    logic [RGB_W-1:0]  bg_rgb  = 24'hFFFFFF;
    logic              op      = OP_ERODE;
    int                col_cnt = 0;
    int                row_cnt = 0;
    bit                fg_seen [STORE_DEPTH];
    px_result_t        due_px [$];
    int                errors  = 0;

    function int clampi(int v, int lo, int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function int eff_w();  return clampi(img_w, 1, 1024); endfunction
    function int eff_h();  return clampi(img_h, 1, 1024); endfunction
    function int eff_ew(); return clampi(el_w, 1, 7); endfunction
    function int eff_eh(); return clampi(el_h, 1, 7); endfunction
    function int frame_total(); return eff_w() * eff_h(); endfunction
    function int flush_len(); return (eff_eh() / 2) * eff_w() + eff_ew() / 2; endfunction
    function int pending(); return due_px.size(); endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_IMAGE_WIDTH:    img_w   = d[DIM_W-1:0];
        REG_IMAGE_HEIGHT:   img_h   = d[DIM_W-1:0];
        REG_ELEMENT_WIDTH:  el_w    = d[ELEM_W-1:0];
        REG_ELEMENT_HEIGHT: el_h    = d[ELEM_W-1:0];
        REG_ELEMENT_MASK:   el_mask = d[MASK_W-1:0];
        REG_FOREGROUND_RGB: fg_rgb  = d[RGB_W-1:0];
        REG_BACKGROUND_RGB: bg_rgb  = d[RGB_W-1:0];
        default:            op      = d[0];
      endcase
      // any register beat restarts the frame
      col_cnt = 0;
      row_cnt = 0;
    endfunction

    function bit fg_at(int r, int c, int w, int h, bit outside);
      if (r < 0 || c < 0 || r >= h || c >= w) return outside;
      return fg_seen[(r * w + c) % STORE_DEPTH];
    endfunction

    function void take_pixel(logic [RGB_W-1:0] pix, logic pad);
      int w, h, ew, eh, cx, cy, delay, total, n, m, ox, oy, b;
      logic [MASK_W-1:0] hits, act;
      bit fg;
      px_result_t e;
      w = eff_w();
      h = eff_h();
      ew = eff_ew();
      eh = eff_eh();
      cx = ew / 2;
      cy = eh / 2;
      delay = cy * w + cx;
      total = w * h;
      n = row_cnt * w + col_cnt;
      if (n < total) fg_seen[n % STORE_DEPTH] = !pad && (pix == fg_rgb);
      if (n >= delay) begin
        m = n - delay;
        ox = m % w;
        oy = m / w;
        hits = '0;
        act = '0;
        for (int j = 0; j < eh; j++) begin
          for (int i = 0; i < ew; i++) begin
            b = j * MASK_STRIDE + i;
            act[b] = el_mask[b];
            if (op == OP_ERODE) hits[b] = fg_at(oy - cy + j, ox - cx + i, w, h, 1'b1);
            else hits[b] = fg_at(oy + cy - j, ox + cx - i, w, h, 1'b0);
          end
        end
        // erosion: no masked position off; dilation: some masked stamp hit
        fg = (op == OP_ERODE) ? ((act & ~hits) == '0) : ((act & hits) != '0);
        e.rgb  = fg ? fg_rgb : bg_rgb;
        e.x    = ox[XY_W-1:0];
        e.y    = oy[XY_W-1:0];
        e.last = (m + 1 == total);
        due_px.push_back(e);
        if (e.last) begin
          col_cnt = 0;
          row_cnt = 0;
          return;
        end
      end
      col_cnt++;
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt = (row_cnt + 1) & 2047;
      end
    endfunction

    function void check_pixel(logic [RGB_W-1:0] rgb, logic [XY_W-1:0] x, logic [XY_W-1:0] y,
                              logic last);
      px_result_t e;
      if (due_px.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat rgb %h x %0d y %0d last %b, expected none",
                 $time, rgb, x, y, last);
        return;
      end
      e = due_px.pop_front();
      if (rgb !== e.rgb) begin
        errors++;
        $display("%0t: result_rgb at (%0d,%0d) expected %h actual %h", $time, e.x, e.y, e.rgb, rgb);
      end
      if (x !== e.x) begin
        errors++;
        $display("%0t: out_x expected %0d actual %0d", $time, e.x, x);
      end
      if (y !== e.y) begin
        errors++;
        $display("%0t: out_y expected %0d actual %0d", $time, e.y, y);
      end
      if (last !== e.last) begin
        errors++;
        $display("%0t: last_pixel at (%0d,%0d) expected %b actual %b", $time, e.x, e.y, e.last,
                 last);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [RGB_W-1:0]      pixel_rgb;
  logic                  is_padding;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [RGB_W-1:0]      result_rgb;
  logic [XY_W-1:0]       out_x;
  logic [XY_W-1:0]       out_y;
  logic                  last_pixel;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  morph_checker morph;
  int src_idle_pct  = 0;   // chance per cycle that the pixel source holds off
  int sink_idle_pct = 0;   // chance per cycle that the result sink stalls
  int beats_sent    = 0;
  bit held_once     = 1'b0;

  binary_morphology_window dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pixel_rgb  (pixel_rgb),
    .is_padding (is_padding),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_rgb (result_rgb),
    .out_x      (out_x),
    .out_y      (out_y),
    .last_pixel (last_pixel),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // Sink stalls are redrawn every falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Every result beat is compared with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) morph.check_pixel(result_rgb, out_x, out_y, last_pixel);
  end

  // One pixel beat; random hold-offs drop valid before it is offered, never after
  task automatic send_beat(input logic [RGB_W-1:0] pix, input logic pad);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    pixel_rgb  <= pix;
    is_padding <= pad;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    morph.take_pixel(pix, pad);
    beats_sent++;
  endtask

  task automatic src_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_empty();
    while (morph.pending() != 0) @(posedge clk);
  endtask

  // Drain the results, then let any beat still in flight without a result clear the pipe
  task automatic settle();
    wait_empty();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    morph.write_reg(idx, d);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Sometimes set junk above the register's own bits; the block must drop it
  function automatic logic [CFG_DATA_W-1:0] with_junk(logic [CFG_DATA_W-1:0] v, int keep);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    if ($urandom_range(3) != 0) return v;
    return v | (junk[CFG_DATA_W-1:0] << keep);
  endfunction

  function automatic logic [RGB_W-1:0] pick_rgb();
    logic [31:0] raw;
    int r;
    raw = $urandom;
    r = $urandom_range(9);
    if (r < 5) return morph.fg_rgb;
    if (r == 5) return 24'h000000;
    if (r == 6) return 24'hFFFFFF;
    return raw[RGB_W-1:0];
  endfunction

  function automatic logic [MASK_W-1:0] pick_mask();
    logic [63:0] a, b;
    int r;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    r = $urandom_range(99);
    if (r < 10) return '1;
    if (r < 20) return '0;
    if (r < 50) return a[MASK_W-1:0] & b[MASK_W-1:0];
    return a[MASK_W-1:0];
  endfunction

  // New random setting; each register is rewritten with some chance, small images mostly
  task automatic shuffle_setup();
    logic [31:0] raw;
    int r;
    r = $urandom_range(99);
    if ($urandom_range(9) < 7)
      set_reg(REG_IMAGE_WIDTH, with_junk((r < 5) ? 0 : ((r < 85) ? $urandom_range(1, 12)
                                                                 : $urandom_range(13, 24)), DIM_W));
    r = $urandom_range(99);
    if ($urandom_range(9) < 7)
      set_reg(REG_IMAGE_HEIGHT, with_junk((r < 5) ? 0 : $urandom_range(1, 8), DIM_W));
    if ($urandom_range(9) < 7) set_reg(REG_ELEMENT_WIDTH, with_junk($urandom_range(7), ELEM_W));
    if ($urandom_range(9) < 7) set_reg(REG_ELEMENT_HEIGHT, with_junk($urandom_range(7), ELEM_W));
    if ($urandom_range(9) < 7) set_reg(REG_ELEMENT_MASK, pick_mask());
    raw = $urandom;
    if ($urandom_range(9) < 7) set_reg(REG_FOREGROUND_RGB, with_junk(raw[RGB_W-1:0], RGB_W));
    raw = $urandom;
    if ($urandom_range(9) < 7) set_reg(REG_BACKGROUND_RGB, with_junk(raw[RGB_W-1:0], RGB_W));
    if ($urandom_range(9) < 7) set_reg(REG_OP_MODE, with_junk($urandom_range(1), 1));
  endtask

  // Clean: whole frame then its flush beats. Cut: frame stopped short, restarted later by a
  // register beat or run on from where it stopped. Noise: loose beats of either kind.
  task automatic run_frame(input int kind);
    int total, flush, n_beats;
    total = morph.frame_total();
    flush = morph.flush_len();
    case (kind)
      FRAME_CLEAN: begin
        for (int k = 0; k < total; k++) begin
          if (!held_once && k >= total / 2 && morph.pending() != 0) begin
            // source holds mid-frame until every released result is out
            src_quiet();
            wait_empty();
            held_once = 1'b1;
          end
          send_beat(pick_rgb(), $urandom_range(19) == 0);
        end
        for (int k = 0; k < flush; k++) send_beat(pick_rgb(), $urandom_range(3) != 0);
      end
      FRAME_CUT: begin
        n_beats = $urandom_range(1, total + flush);
        for (int k = 0; k < n_beats; k++) send_beat(pick_rgb(), $urandom_range(9) == 0);
      end
      default: begin
        n_beats = $urandom_range(1, 24);
        for (int k = 0; k < n_beats; k++) send_beat(pick_rgb(), $urandom_range(1));
      end
    endcase
    src_quiet();
    settle();
  endtask

  initial begin
    int target, r;
    rst        = 1'b1;
    in_valid   = 1'b0;
    pixel_rgb  = '0;
    is_padding = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_IMAGE_WIDTH;
    cfg_data   = '0;
    morph = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    src_idle_pct  = 12;
    sink_idle_pct = 71;

    // 4x2 erosion, full mask with bits beyond the element set; padding inside the frame
    // reads as background and plain pixels after the frame act as flush
    set_reg(REG_IMAGE_WIDTH, 4);
    set_reg(REG_IMAGE_HEIGHT, 2);
    set_reg(REG_ELEMENT_WIDTH, 3);
    set_reg(REG_ELEMENT_HEIGHT, 3);
    set_reg(REG_ELEMENT_MASK, '1);
    set_reg(REG_FOREGROUND_RGB, 24'h000000);
    set_reg(REG_BACKGROUND_RGB, 24'hFFFFFF);
    set_reg(REG_OP_MODE, OP_ERODE);
    send_beat(24'h000000, 1'b0);
    send_beat(24'h000000, 1'b0);
    send_beat(24'h000000, 1'b0);
    send_beat(24'hFFFFFF, 1'b0);
    send_beat(24'h000000, 1'b0);
    send_beat(24'h000000, 1'b1);
    send_beat(24'h000000, 1'b0);
    send_beat(24'h000000, 1'b0);
    send_beat(24'hFFFFFF, 1'b1);
    send_beat(24'h000000, 1'b1);
    send_beat(24'h000000, 1'b1);
    send_beat(24'h000000, 1'b0);
    send_beat(24'hFFFFFF, 1'b0);
    src_quiet();
    settle();

    // Zero sizes clamp to one; empty mask erodes to all foreground with no delay
    set_reg(REG_IMAGE_WIDTH, 0);
    set_reg(REG_IMAGE_HEIGHT, 3);
    set_reg(REG_ELEMENT_WIDTH, 0);
    set_reg(REG_ELEMENT_HEIGHT, 0);
    set_reg(REG_ELEMENT_MASK, '0);
    send_beat(24'hFFFFFF, 1'b0);
    send_beat(24'h000000, 1'b0);
    send_beat(24'hFFFFFF, 1'b1);
    src_quiet();
    settle();

    // 7x7 dilation over a 2x2 image: the delay outlasts the frame
    set_reg(REG_IMAGE_WIDTH, 2);
    set_reg(REG_IMAGE_HEIGHT, 2);
    set_reg(REG_ELEMENT_WIDTH, 7);
    set_reg(REG_ELEMENT_HEIGHT, 7);
    set_reg(REG_ELEMENT_MASK, pick_mask());
    set_reg(REG_FOREGROUND_RGB, 24'hFFFFFF);
    set_reg(REG_BACKGROUND_RGB, 24'h000000);
    set_reg(REG_OP_MODE, OP_DILATE);
    run_frame(FRAME_CLEAN);

    // Random part: source idles lightly then heavily, then neither side idles
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle_pct  = 12;
          sink_idle_pct = 71;
        end
        1: begin
          src_idle_pct  = 71;
          sink_idle_pct = 12;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      target = beats_sent + PHASE_BEATS;
      while (beats_sent < target) begin
        shuffle_setup();
        r = $urandom_range(99);
        run_frame((r < 72) ? FRAME_CLEAN : ((r < 88) ? FRAME_CUT : FRAME_NOISE));
      end
    end

    settle();
    if (morph.errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

  // Watchdog, far beyond the slowest correct run
  initial begin
    #3_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
